### design/isort_pkg.sv
// Shared constants and types for the insertion sorter.
package isort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DRAIN
    } cell_op_t;

    // What one cell shows to its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     greater;
        logic signed [DATA_W-1:0] data;
    } cell_link_t;

endpackage

### design/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
module isort_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  isort_pkg::cell_op_t               op,
    input  logic signed [isort_pkg::DATA_W-1:0] in_word,
    input  isort_pkg::cell_link_t             left_link,
    input  isort_pkg::cell_link_t             right_link,
    output isort_pkg::cell_link_t             own_link
);
    import isort_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     greater;
    logic                     insert_here;

    // Flag a stored word that must move right to make room
    assign greater = valid_reg && (data_reg > in_word);

    // Take the new word where the left side stays and this cell moves or is empty
    assign insert_here = left_link.valid && !left_link.greater && (greater || !valid_reg);

    assign own_link.valid   = valid_reg;
    assign own_link.greater = greater;
    assign own_link.data    = data_reg;

    // Select the next contents of the cell
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (op)
            CELL_INSERT: begin
                if (left_link.greater) begin
                    data_next  = left_link.data;
                    valid_next = 1'b1;
                end else if (insert_here) begin
                    data_next  = in_word;
                    valid_next = 1'b1;
                end
            end
            CELL_DRAIN: begin
                data_next  = right_link.data;
                valid_next = right_link.valid;
            end
            default: begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    // Hold the cell contents; reset empties the cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

### design/insertion_sorter_unit.sv
// Top level of the insertion sorter: cell chain and load/drain control.
//
// Usage: signed 32-bit words enter on the s_ channel (s_value, s_end_of_set)
// and are placed into a chain of MAX_ELEMENTS compare-and-shift cells, kept in
// ascending order; equal words keep their arrival order. Loading takes one
// word per clock. The word that carries s_end_of_set is inserted like any
// other, then the set drains out of the chain on the m_ channel in ascending
// order, one word per clock while m_ready is high. Once the end-of-set word
// is accepted the unit enters the drain state, and from there the first
// result is loaded into the output register; s_ready stays low while the set
// drains. m_final_result marks the largest, last word. Words that arrive
// while every cell is full are dropped, and m_overflowed is set on every
// result of that set. A new set may start loading as soon as the last result
// sits in the output register. A stall on m_ready holds the output register
// and halts the drain. Reset (aresetn low, synchronous) empties the chain,
// clears the internal overflow flag (drop_reg) and m_valid, and returns to loading.
module insertion_sorter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [isort_pkg::DATA_W-1:0] s_value,
    input  logic                                s_end_of_set,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [isort_pkg::DATA_W-1:0] m_sorted_value,
    output logic                                m_final_result,
    output logic                                m_overflowed
);
    import isort_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    localparam cell_link_t EDGE_LEFT  = '{valid: 1'b1, greater: 1'b0, data: '0};
    localparam cell_link_t EDGE_RIGHT = '{valid: 1'b0, greater: 1'b0, data: '0};

    state_t                   state_reg;
    state_t                   state_next;
    logic                     drop_reg;
    logic                     drop_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [DATA_W-1:0] m_value_reg;
    logic signed [DATA_W-1:0] m_value_next;
    logic                     m_final_reg;
    logic                     m_final_next;
    logic                     m_ovf_reg;
    logic                     m_ovf_next;

    cell_op_t                 op;
    cell_link_t               links [MAX_ELEMENTS];
    logic                     in_fire;
    logic                     out_load;
    logic                     store_full;
    logic                     last_word;

    // Build the chain of cells
    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        cell_link_t left_l;
        cell_link_t right_l;
        if (i == 0) begin : g_first
            assign left_l = EDGE_LEFT;
        end else begin : g_inner_left
            assign left_l = links[i-1];
        end
        if (i == MAX_ELEMENTS - 1) begin : g_last
            assign right_l = EDGE_RIGHT;
        end else begin : g_inner_right
            assign right_l = links[i+1];
        end
        isort_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .in_word    (s_value),
            .left_link  (left_l),
            .right_link (right_l),
            .own_link   (links[i])
        );
    end

    assign s_ready    = (state_reg == ST_LOAD);
    assign in_fire    = s_valid && s_ready;
    assign store_full = links[MAX_ELEMENTS-1].valid;
    assign out_load   = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);
    assign last_word  = !links[1].valid;

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_final_result = m_final_reg;
    assign m_overflowed   = m_ovf_reg;

    // Sequence loading and draining
    always_comb begin
        state_next   = state_reg;
        drop_next    = drop_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_final_next = m_final_reg;
        m_ovf_next   = m_ovf_reg;
        op           = CELL_HOLD;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (store_full) begin
                        drop_next = 1'b1;
                    end else begin
                        op = CELL_INSERT;
                    end
                    if (s_end_of_set) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    op           = CELL_DRAIN;
                    m_valid_next = 1'b1;
                    m_value_next = links[0].data;
                    m_final_next = last_word;
                    m_ovf_next   = drop_reg;
                    if (last_word) begin
                        state_next = ST_LOAD;
                        drop_next  = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold state and the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
        m_value_reg <= m_value_next;
        m_final_reg <= m_final_next;
        m_ovf_reg   <= m_ovf_next;
    end

endmodule
